// ===== hdl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch-to-calendar converter
// Holds field widths, calendar constants, the month-length table and the
// structs passed between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Field widths.
  localparam int unsigned EpochW = 33;
  localparam int unsigned ZoneW  = 5;
  localparam int unsigned DivW   = 16;
  localparam int unsigned QuoW   = 22;

  // Operand and product widths of the shared multiplier.
  localparam int unsigned MulAW  = 29;
  localparam int unsigned MulBW  = 30;
  localparam int unsigned ProdW  = MulAW + MulBW;

  // Calendar constants.
  localparam logic signed [12:0] SecPerHour  = 13'sd3600;
  localparam logic [DivW-1:0]    Div3600     = 16'd3600;
  localparam logic [DivW-1:0]    Div60       = 16'd60;
  localparam logic [DivW-1:0]    Div24       = 16'd24;
  localparam logic [DivW-1:0]    HoursPer4Y  = 16'd35064;
  localparam logic [DivW-1:0]    HoursPerYr  = 16'd8760;
  localparam logic [DivW-1:0]    HoursPerLp  = 16'd8784;
  localparam logic [7:0]         BaseYear    = 8'd70;
  localparam logic [8:0]         LeapDay     = 9'd60;
  localparam logic [8:0]         Feb29       = 9'd29;
  localparam logic [3:0]         MonthFeb    = 4'd1;
  localparam logic [3:0]         LastMonth   = 4'd11;
  localparam logic [ZoneW-1:0]   ZoneReset   = 5'd8;

  // Reciprocals for division by a constant: the quotient is
  // ((x >> pre) * recip) >> shift, exact over the whole dividend range
  // of each use. Seconds are below 2^33, so they are scaled down by 16
  // and divided by 225; the remainder of 60 is below 3600, total hours
  // are below 2^21 and hours within a year are below 2^14.
  localparam int unsigned        Pre3600     = 4;
  localparam logic [MulBW-1:0]   Recip3600   = 30'd610839794;  // ceil(2^37 / 225)
  localparam int unsigned        Shift3600   = 37;
  localparam logic [MulBW-1:0]   Recip60     = 30'd4370;       // ceil(2^18 / 60)
  localparam int unsigned        Shift60     = 18;
  localparam logic [MulBW-1:0]   Recip4Y     = 30'd3919660;    // ceil(2^37 / 35064)
  localparam int unsigned        Shift4Y     = 37;
  localparam logic [MulBW-1:0]   Recip24     = 30'd21846;      // ceil(2^19 / 24)
  localparam int unsigned        Shift24     = 19;

  // Divisor selection for the shared divider.
  typedef enum logic [1:0] {
    DivBy3600,
    DivBy60,
    DivBy4Y,
    DivBy24
  } div_sel_e;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [EpochW-1:0] dividend;
    div_sel_e          sel;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic              done;
    logic [QuoW-1:0]   quo;
    logic [DivW-1:0]   rem;
  } div_rsp_t;

  // One calendar result.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] year_since_1900;
  } res_t;

  // Days in each month of a common year, January is zero.
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/esc_div.sv =====
// ----------------------------------------------------------------------------
// esc_div: shared constant divider
// Divides an unsigned dividend by one of four constants on a single shared
// multiplier: a reciprocal product gives the quotient, a second product and
// a subtraction give the remainder. Done pulses once the remainder is
// registered; quotient and remainder hold until the next request.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esc_pkg::div_req_t req_i,
  output esc_pkg::div_rsp_t rsp_o
);
  import esc_pkg::*;

  localparam logic [1:0] PIdle  = 2'd0;
  localparam logic [1:0] PRecip = 2'd1;
  localparam logic [1:0] PBack  = 2'd2;
  localparam logic [1:0] PRem   = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic              done_q, done_d;
  logic [EpochW-1:0] num_q, num_d;
  div_sel_e          sel_q, sel_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [MulAW-1:0]  num_scaled;
  logic [MulBW-1:0]  recip;
  logic [QuoW-1:0]   quo_est;
  logic [DivW-1:0]   dvs;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  mul_p;
  logic [EpochW-1:0] diff;

  // Constants of the selected divisor.
  always_comb begin
    case (sel_q)
      DivBy3600: begin
        num_scaled = MulAW'(num_q >> Pre3600);
        recip      = Recip3600;
        quo_est    = QuoW'(prod_q >> Shift3600);
        dvs        = Div3600;
      end
      DivBy60: begin
        num_scaled = MulAW'(num_q);
        recip      = Recip60;
        quo_est    = QuoW'(prod_q >> Shift60);
        dvs        = Div60;
      end
      DivBy4Y: begin
        num_scaled = MulAW'(num_q);
        recip      = Recip4Y;
        quo_est    = QuoW'(prod_q >> Shift4Y);
        dvs        = HoursPer4Y;
      end
      default: begin
        // Division by 24.
        num_scaled = MulAW'(num_q);
        recip      = Recip24;
        quo_est    = QuoW'(prod_q >> Shift24);
        dvs        = Div24;
      end
    endcase
  end

  // Shared multiplier: reciprocal product first, then quotient times divisor.
  assign mul_a = (phase_q == PBack) ? MulAW'(quo_est) : num_scaled;
  assign mul_b = (phase_q == PBack) ? MulBW'(dvs) : recip;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);
  assign diff  = num_q - prod_q[EpochW-1:0];

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    num_d   = num_q;
    sel_d   = sel_q;
    quo_d   = quo_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    case (phase_q)
      PRecip: begin
        prod_d  = mul_p;
        phase_d = PBack;
      end
      PBack: begin
        quo_d   = quo_est;
        prod_d  = mul_p;
        phase_d = PRem;
      end
      PRem: begin
        rem_d   = diff[DivW-1:0];
        done_d  = 1'b1;
        phase_d = PIdle;
      end
      default: begin
        if (req_i.start) begin
          num_d   = req_i.dividend;
          sel_d   = req_i.sel;
          phase_d = PRecip;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PIdle;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    sel_q  <= sel_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl: conversion sequencer
// Steps one clamped seconds count through the shared divider, the year walk,
// the leap-day fix and the month walk, then offers the calendar result.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [esc_pkg::EpochW-1:0] secs_i,
  output logic                       ready_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output esc_pkg::res_t              res_o
);
  import esc_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SHrs   = 4'd1;
  localparam logic [3:0] SMin   = 4'd2;
  localparam logic [3:0] SQuad  = 4'd3;
  localparam logic [3:0] SYear  = 4'd4;
  localparam logic [3:0] SDay   = 4'd5;
  localparam logic [3:0] SLeap  = 4'd6;
  localparam logic [3:0] SMonth = 4'd7;
  localparam logic [3:0] SDone  = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [5:0]      sec_q, sec_d, min_q, min_d;
  logic [4:0]      hr_q, hr_d;
  logic [7:0]      year_q, year_d;
  logic [QuoW-1:0] hrs_q, hrs_d;
  logic [DivW-1:0] hours_q, hours_d;
  logic [8:0]      day_q, day_d;
  logic [3:0]      mon_q, mon_d;
  logic            leap;
  logic [DivW-1:0] year_len;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  esc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Every fourth year is a leap year.
  assign leap     = year_q[1:0] == 2'b00;
  assign year_len = leap ? HoursPerLp : HoursPerYr;

  // Sequencer and walk steps.
  always_comb begin
    state_d = state_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hr_d    = hr_q;
    year_d  = year_q;
    hrs_d   = hrs_q;
    hours_d = hours_q;
    day_d   = day_q;
    mon_d   = mon_q;
    div_req = '{start: 1'b0, dividend: '0, sel: DivBy60};
    case (state_q)
      SIdle: begin
        if (start_i) begin
          div_req = '{start: 1'b1, dividend: secs_i, sel: DivBy3600};
          state_d = SHrs;
        end
      end
      SHrs: begin
        // Whole hours are kept; the seconds within the hour are split next.
        if (div_rsp.done) begin
          hrs_d   = div_rsp.quo;
          div_req = '{start: 1'b1, dividend: EpochW'(div_rsp.rem), sel: DivBy60};
          state_d = SMin;
        end
      end
      SMin: begin
        if (div_rsp.done) begin
          sec_d   = div_rsp.rem[5:0];
          min_d   = div_rsp.quo[5:0];
          div_req = '{start: 1'b1, dividend: EpochW'(hrs_q), sel: DivBy4Y};
          state_d = SQuad;
        end
      end
      SQuad: begin
        if (div_rsp.done) begin
          year_d  = BaseYear + {div_rsp.quo[5:0], 2'b00};
          hours_d = div_rsp.rem;
          state_d = SYear;
        end
      end
      SYear: begin
        if (hours_q < year_len) begin
          div_req = '{start: 1'b1, dividend: EpochW'(hours_q), sel: DivBy24};
          state_d = SDay;
        end else begin
          hours_d = hours_q - year_len;
          year_d  = year_q + 8'd1;
        end
      end
      SDay: begin
        if (div_rsp.done) begin
          hr_d    = div_rsp.rem[4:0];
          day_d   = div_rsp.quo[8:0] + 9'd1;
          state_d = SLeap;
        end
      end
      SLeap: begin
        mon_d = '0;
        if (leap && day_q == LeapDay) begin
          mon_d   = MonthFeb;
          day_d   = Feb29;
          state_d = SDone;
        end else begin
          if (leap && day_q > LeapDay) begin
            day_d = day_q - 9'd1;
          end
          state_d = SMonth;
        end
      end
      SMonth: begin
        if (mon_q < LastMonth && {4'b0000, month_len(mon_q)} < day_q) begin
          day_d = day_q - {4'b0000, month_len(mon_q)};
          mon_d = mon_q + 4'd1;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    sec_q   <= sec_d;
    min_q   <= min_d;
    hr_q    <= hr_d;
    year_q  <= year_d;
    hrs_q   <= hrs_d;
    hours_q <= hours_d;
    day_q   <= day_d;
    mon_q   <= mon_d;
  end

  assign ready_o     = state_q == SIdle;
  assign res_valid_o = state_q == SDone;

  assign res_o.second          = sec_q;
  assign res_o.minute          = min_q;
  assign res_o.hour            = hr_q;
  assign res_o.day_of_month    = day_q[4:0];
  assign res_o.month           = mon_q;
  assign res_o.year_since_1900 = year_q;

endmodule

// ===== hdl/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to calendar date and time
//
// The input channel (in_valid_i / in_stall_o) carries a signed 33-bit count
// of seconds since 1970-01-01 UTC. The user writes the zone offset register
// over the cfg_valid_i / cfg_ready_o channel only while the block is idle;
// the block itself does not enforce this. The offset adds whole hours first;
// a negative sum is clamped to zero. Every fourth year is a leap year. Each
// transfer in gives one transfer out on the output channel (out_valid_o /
// out_stall_i) with second, minute, hour, day of month, zero-based month and
// year since 1900. One item passes through four divisions on the shared
// multiplier, up to three year steps and up to eleven month steps before
// its result is valid; the leap day skips the month walk. in_stall_o stays
// high while an item is in work, so the block takes no new item before it
// is through with the last one. The result sits in an output
// register, so the next item is taken while it waits; a stalled receiver
// holds the result and the sequencer waits with the following one until
// the register frees.
// Reset clears the channels and sets the zone offset to eight hours.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [esc_pkg::ZoneW-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [esc_pkg::EpochW-1:0] epoch_seconds_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [5:0]                        second_o,
  output logic [5:0]                        minute_o,
  output logic [4:0]                        hour_o,
  output logic [4:0]                        day_of_month_o,
  output logic [3:0]                        month_o,
  output logic [7:0]                        year_since_1900_o
);
  import esc_pkg::*;

  logic signed [ZoneW-1:0]  zone_q;
  logic signed [17:0]       zone_secs;
  logic signed [EpochW:0]   sum;
  logic [EpochW-1:0]        secs_clamped;
  logic                     ctrl_ready;
  logic                     in_xfer;
  logic                     res_valid;
  logic                     res_ready;
  res_t                     res;
  logic                     out_valid_q;
  res_t                     out_q;

  // Zone offset register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= ZoneReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      zone_q <= cfg_data_i;
    end
  end

  // Offset in seconds, sum and clamp at zero.
  assign zone_secs    = 18'(zone_q) * 18'(SecPerHour);
  assign sum          = {epoch_seconds_i[EpochW-1], epoch_seconds_i}
                      + {{(EpochW-17){zone_secs[17]}}, zone_secs};
  assign secs_clamped = sum[EpochW] ? '0 : sum[EpochW-1:0];

  // Input handshake.
  assign in_stall_o = !ctrl_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .secs_i      (secs_clamped),
    .ready_o     (ctrl_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or when its result transfers out.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign second_o          = out_q.second;
  assign minute_o          = out_q.minute;
  assign hour_o            = out_q.hour;
  assign day_of_month_o    = out_q.day_of_month;
  assign month_o           = out_q.month;
  assign year_since_1900_o = out_q.year_since_1900;

endmodule

// ===== tb/epoch_seconds_to_calendar_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb: self-checking bench for the calendar converter
// A queue of pending jobs feeds a clocked driver with epoch counts, zone
// offset writes and pauses. A clocked monitor predicts the calendar date of
// every accepted count and compares it with the results in order. Both
// sides insert random gaps, and the receiver holds off long enough to stall
// the input.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;

  import esc_pkg::*;

  typedef enum logic [1:0] {
    OP_EPOCH,
    OP_ZONE,
    OP_DRAIN
  } job_op_e;

  // One pending job for the driver; gap is the idle time after an epoch count.
  typedef struct {
    job_op_e           op;
    logic signed [32:0] secs;
    logic signed [4:0]  zone;
    int unsigned        gap;
  } job_t;

  // One predicted date together with what produced it.
  typedef struct {
    res_t               cal;
    logic signed [32:0] secs;
    logic signed [4:0]  zone;
  } due_date_t;

  localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30,
                                               31, 31, 30, 31, 30, 31};
  localparam longint      EpochMax      = 64'sd4294967295;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldCycles    = 1000;
  localparam int unsigned TailCycles    = 400;
  localparam int unsigned WatchdogLimit = 8000;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseItems    = 150;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic signed [4:0]  cfg_data_i        = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic signed [32:0] epoch_seconds_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [5:0]         second_o;
  logic [5:0]         minute_o;
  logic [4:0]         hour_o;
  logic [4:0]         day_of_month_o;
  logic [3:0]         month_o;
  logic [7:0]         year_since_1900_o;

  job_t        job_q[$];
  due_date_t   dates_due[$];
  logic signed [4:0] zone_now = ZoneReset;
  logic        in_acc  = 1'b0;
  logic        cfg_acc = 1'b0;
  bit          stim_done = 1'b0;
  int unsigned gap_left = 0;
  int unsigned settle_cnt = 0;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_done = 0;
  int unsigned rx_phase_left = 0;
  bit          rx_calm = 1'b0;

  // Next values of the driver, computed before the single update per edge.
  logic               nx_in_v;
  logic signed [32:0] nx_secs;
  logic               nx_cfg_v;
  logic signed [4:0]  nx_zone;

  // Monitor scratch values.
  res_t      got_cal;
  due_date_t want;

  epoch_seconds_to_calendar DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .epoch_seconds_i   (epoch_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .second_o          (second_o),
    .minute_o          (minute_o),
    .hour_o            (hour_o),
    .day_of_month_o    (day_of_month_o),
    .month_o           (month_o),
    .year_since_1900_o (year_since_1900_o)
  );

  always #5 clk_i = ~clk_i;

  // Calendar date for a seconds count under a zone offset; every fourth year
  // is a leap year and a negative sum stands for the epoch itself.
  function automatic res_t calendar_of(input logic signed [32:0] secs,
                                       input logic signed [4:0] zone);
    longint total;
    longint hrs;
    longint span;
    int unsigned yr;
    int unsigned day;
    int unsigned mon;
    res_t r;
    total = longint'(secs) + longint'(zone) * 3600;
    if (total < 0) begin
      total = 0;
    end
    r.second = 6'(total % 60);
    total = total / 60;
    r.minute = 6'(total % 60);
    hrs = total / 60;
    yr = 70 + 4 * int'(hrs / 35064);
    hrs = hrs % 35064;
    span = (yr % 4 == 0) ? 8784 : 8760;
    while (hrs >= span) begin
      hrs = hrs - span;
      yr++;
      span = (yr % 4 == 0) ? 8784 : 8760;
    end
    r.hour = 5'(hrs % 24);
    day = int'(hrs / 24) + 1;
    mon = 0;
    // The leap day is reported directly; later days of a leap year slide back
    // by one so that the common-year table applies.
    if (yr % 4 == 0 && day == 60) begin
      mon = 1;
      day = 29;
    end else begin
      if (yr % 4 == 0 && day > 60) begin
        day--;
      end
      while (mon < 11 && DaysInMonth[mon] < day) begin
        day = day - DaysInMonth[mon];
        mon++;
      end
    end
    r.day_of_month    = 5'(day);
    r.month           = 4'(mon);
    r.year_since_1900 = 8'(yr);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned draw_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (calm || r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(3, 1);
    end
    if (r < 97) begin
      return $urandom_range(30, 4);
    end
    return $urandom_range(300, 60);
  endfunction

  // Random seconds count, weighted toward year ends, leap days, zero and the top.
  function automatic logic signed [32:0] pick_epoch();
    int unsigned sel;
    int          y;
    int          dd;
    longint      s;
    logic [32:0] bits;
    sel = $urandom_range(99, 0);
    if (sel < 12) begin
      bits[31:0] = $urandom();
      bits[32]   = 1'($urandom_range(1, 0));
      return bits;
    end
    if (sel < 45) begin
      s = longint'($urandom());
    end else if (sel < 75) begin
      y = int'($urandom_range(135, 0));
      case ($urandom_range(2, 0))
        0:       dd = int'($urandom_range(3, 0)) - 1;
        1:       dd = int'($urandom_range(62, 57));
        default: dd = int'($urandom_range(365, 0));
      endcase
      s = (longint'(y) * 365 + (y + 1) / 4 + dd) * 86400
          + longint'($urandom_range(86399, 0));
    end else if (sel < 87) begin
      s = longint'($urandom_range(400000, 0)) - 200000;
    end else begin
      s = EpochMax - longint'($urandom_range(200000, 0));
    end
    if (s > EpochMax) begin
      s = EpochMax;
    end
    return 33'(s);
  endfunction

  function automatic void add_epoch(input logic signed [32:0] s, input bit calm);
    job_t j;
    j.op   = OP_EPOCH;
    j.secs = s;
    j.zone = '0;
    j.gap  = draw_gap(calm);
    job_q.push_back(j);
  endfunction

  function automatic void add_zone(input logic signed [4:0] z);
    job_t j;
    j.op   = OP_ZONE;
    j.secs = '0;
    j.zone = z;
    j.gap  = 0;
    job_q.push_back(j);
  endfunction

  function automatic void add_drain();
    job_t j;
    j.op   = OP_DRAIN;
    j.secs = '0;
    j.zone = '0;
    j.gap  = 0;
    job_q.push_back(j);
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    // Directed counts under the reset offset of eight hours.
    add_epoch(0, 1'b0);
    add_epoch(1, 1'b0);
    add_epoch(-1, 1'b0);
    add_epoch(-28800, 1'b0);
    add_epoch(-28801, 1'b0);
    add_epoch(-28799, 1'b0);
    add_epoch(3599, 1'b0);
    add_epoch(86399, 1'b0);
    add_epoch(33'h1_0000_0000, 1'b0);
    add_epoch(33'sd4294967295, 1'b0);
    add_epoch(33'sd2147483647, 1'b0);
    add_epoch(-33'sd2147483648, 1'b0);
    add_epoch(68169600 - 28800, 1'b0);
    add_epoch(951782400 - 28800, 1'b0);
    add_epoch(951868800 - 28800 - 1, 1'b0);
    add_epoch(946684800 - 28800 - 1, 1'b0);
    add_epoch(946684800 - 28800, 1'b0);
    add_epoch(33'sd4107513600, 1'b0);
    add_epoch(33'sd4107600000, 1'b0);
    // The most negative offset, around its clamping point.
    add_zone(-5'sd16);
    add_epoch(57600, 1'b0);
    add_epoch(57599, 1'b0);
    add_epoch(33'sd4294967295, 1'b0);
    // The largest offset gives the largest sum.
    add_zone(5'sd15);
    add_epoch(33'sd4294967295, 1'b0);
    add_epoch(-54000, 1'b0);

    // Random phases, each under its own offset; some run without gaps.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       add_zone(5'sd15);
        1:       add_zone(-5'sd12);
        2:       add_zone(5'sd14);
        3:       add_zone(5'sd0);
        4:       add_zone(-5'sd1);
        7:       add_zone(5'sd8);
        default: add_zone(5'($urandom_range(31, 0)));
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        if ((ph == 3 || ph == 6) && k == PhaseItems / 2) begin
          add_drain();
        end
        add_epoch(pick_epoch(), ph % 3 == 1);
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(stim_done && dates_due.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Driver: one transfer at a time on either the input or the zone channel.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      nx_in_v  = in_valid_i && !in_acc;
      nx_cfg_v = cfg_valid_i && !cfg_acc;
      nx_secs  = epoch_seconds_i;
      nx_zone  = cfg_data_i;
      // Count quiet cycles once every predicted date has come back.
      if (dates_due.size() != 0 || nx_in_v) begin
        settle_cnt = 0;
      end else if (settle_cnt < SettleCycles) begin
        settle_cnt++;
      end
      if (nx_in_v || nx_cfg_v) begin
        // A transfer is still waiting; its payload stays as it is.
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (job_q.size() == 0) begin
        stim_done = 1'b1;
      end else begin
        case (job_q[0].op)
          OP_EPOCH: begin
            nx_in_v  = 1'b1;
            nx_secs  = job_q[0].secs;
            gap_left = job_q[0].gap;
            void'(job_q.pop_front());
          end
          OP_ZONE: begin
            if (settle_cnt == SettleCycles) begin
              nx_cfg_v = 1'b1;
              nx_zone  = job_q[0].zone;
              void'(job_q.pop_front());
            end
          end
          default: begin
            if (settle_cnt == SettleCycles) begin
              void'(job_q.pop_front());
            end
          end
        endcase
      end
      in_valid_i      <= nx_in_v;
      epoch_seconds_i <= nx_secs;
      cfg_valid_i     <= nx_cfg_v;
      cfg_data_i      <= nx_zone;
    end
  end

  // Receiver: random stalls with calm stretches, plus two long hold-offs.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_phase_left == 0) begin
        rx_calm       = ($urandom_range(3, 0) == 0);
        rx_phase_left = $urandom_range(3000, 500);
      end else begin
        rx_phase_left--;
      end
      if (hold_done < 2 && items_taken >= ((hold_done == 0) ? 250 : 800)) begin
        hold_left = HoldCycles;
        hold_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = draw_gap(rx_calm);
        if (stall_left != 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: track the offset, predict each accepted count, check each result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_acc  <= in_valid_i && !in_stall_o;
      cfg_acc <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        zone_now = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        want.cal  = calendar_of(epoch_seconds_i, zone_now);
        want.secs = epoch_seconds_i;
        want.zone = zone_now;
        dates_due.push_back(want);
        items_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        got_cal.second          = second_o;
        got_cal.minute          = minute_o;
        got_cal.hour            = hour_o;
        got_cal.day_of_month    = day_of_month_o;
        got_cal.month           = month_o;
        got_cal.year_since_1900 = year_since_1900_o;
        if (dates_due.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got_cal.year_since_1900,
                     got_cal.month, got_cal.day_of_month, got_cal.hour,
                     got_cal.minute, got_cal.second);
          end
        end else begin
          want = dates_due.pop_front();
          if (got_cal.second !== want.cal.second || got_cal.minute !== want.cal.minute ||
              got_cal.hour !== want.cal.hour ||
              got_cal.day_of_month !== want.cal.day_of_month ||
              got_cal.month !== want.cal.month ||
              got_cal.year_since_1900 !== want.cal.year_since_1900) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display("mismatch secs=%0d zone=%0d exp %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                       want.secs, want.zone, want.cal.year_since_1900, want.cal.month,
                       want.cal.day_of_month, want.cal.hour, want.cal.minute,
                       want.cal.second, got_cal.year_since_1900, got_cal.month,
                       got_cal.day_of_month, got_cal.hour, got_cal.minute,
                       got_cal.second);
            end
          end
        end
      end
      // Watchdog over cycles in which no transfer happens on any channel.
      if ((in_valid_i && !in_stall_o) || (cfg_valid_i && cfg_ready_o) ||
          (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
